[src/dcpm_pkg.sv]
// Shared types, codes and batch constants for the DC power monitor averager.
package dcpm_pkg;

    // Batch sizes, as log2 of the number of samples per batch
    localparam int CURRENT_SAMPLES_LOG2 = 4;
    localparam int VOLTAGE_SAMPLES_LOG2 = 4;

    localparam int COUNT_W = 7;
    localparam logic [COUNT_W-1:0] CUR_BATCH = COUNT_W'(1 << CURRENT_SAMPLES_LOG2);
    localparam logic [COUNT_W-1:0] VOLT_BATCH = COUNT_W'(1 << VOLTAGE_SAMPLES_LOG2);

    // Shift that turns a batch sum into a Q10.6 average
    localparam int CUR_AVG_SHIFT = 6 - CURRENT_SAMPLES_LOG2;
    localparam int VOLT_AVG_SHIFT = 6 - VOLTAGE_SAMPLES_LOG2;

    // Mid-scale zero-current offset, 512.0 in Q10.6
    localparam logic [15:0] OFFSET_RESET = 16'(512 << 6);

    // Register reset values
    localparam logic [15:0] CURRENT_GAIN_RESET = 16'd6758;
    localparam logic [15:0] VOLTAGE_GAIN_RESET = 16'd1250;
    localparam logic [9:0] LIMIT_RESET = 10'd1023;

    // Rounding constant for the Q10.6 x Q8.8 product (14 fraction bits)
    localparam logic [32:0] ROUND_HALF = 33'd8192;

    // Item op codes
    localparam logic [1:0] OP_MEASURE = 2'd0;
    localparam logic [1:0] OP_CALIB = 2'd1;
    localparam logic [1:0] OP_VOLTAGE = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_CALIBRATED = 2'd0;
    localparam logic [1:0] STATUS_MEAS_DONE = 2'd1;
    localparam logic [1:0] STATUS_CUR_FAULT = 2'd2;
    localparam logic [1:0] STATUS_VOLT_FAULT = 2'd3;

    // Configuration register indexes
    localparam logic [7:0] REG_CURRENT_GAIN = 8'd0;
    localparam logic [7:0] REG_VOLTAGE_GAIN = 8'd1;
    localparam logic [7:0] REG_CURRENT_LIMIT = 8'd2;
    localparam logic [7:0] REG_VOLTAGE_LIMIT = 8'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [9:0] sample;
    } dcpm_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] current_ma;
        logic [15:0] voltage_mv;
        logic [31:0] power_uw;
        logic [15:0] zero_offset;
    } dcpm_out_t;

endpackage

[src/dcpm_serial_mult.sv]
// Bit-serial 16 x 16 unsigned shift-add multiplier, one multiplier bit per cycle.
module dcpm_serial_mult import dcpm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic        done,
    output logic [31:0] product
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] a_reg, a_next;
    logic [31:0] prod_reg, prod_next;
    logic [16:0] partial;

    // Add the multiplicand into the upper half when the current bit is set
    assign partial = {1'b0, prod_reg[31:16]} + (prod_reg[0] ? {1'b0, a_reg} : 17'd0);

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        prod_next = prod_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            a_next    = a;
            prod_next = {16'd0, b};
        end else if (busy_reg) begin
            prod_next = {partial, prod_reg[15:1]};
            cnt_next  = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and product shift register
    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

[src/dc_power_monitor_averager.sv]
// Top level of the DC power monitor averager: batch averaging, scaling and result output.
//
// Input items (s_valid/s_ready/s_data) carry an op tag and a raw 10-bit sample.
// Current samples (measure or calibration) share one batch of 2^CURRENT_SAMPLES_LOG2,
// voltage samples a batch of 2^VOLTAGE_SAMPLES_LOG2. At most one result item per
// input item leaves on m_valid/m_ready/m_data: calibration done, measurement done
// (at the end of a voltage batch) or a channel fault on an over-limit sample.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the user is to
// write them only while idle, as the block itself does not enforce it. One item is
// worked on at a time. Scaling and the power product use one shared bit-serial 16x16
// multiplier. A plain sample or op 3 gives no result, nor does the end of a measurement
// batch, which only scales the current; a fault or calibration runs the power product
// before its result, and the end of a voltage batch scales the voltage, then runs the
// power product.
// A finished result sits in the output register; the next item is taken while it
// waits, and that item only stalls when its own result is ready before m_ready.
// Reset (aresetn low, synchronous) clears the batches, held values and output and
// restores the mid-scale offset and the register defaults.
module dc_power_monitor_averager import dcpm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  dcpm_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output dcpm_out_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_MUL_I = 3'd2;
    localparam logic [2:0] ST_MUL_V = 3'd3;
    localparam logic [2:0] ST_MUL_P = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    dcpm_in_t    item_reg, item_next;
    logic [1:0]  status_reg, status_next;

    logic [15:0] cur_gain_reg, cur_gain_next;
    logic [15:0] volt_gain_reg, volt_gain_next;
    logic [9:0]  cur_limit_reg, cur_limit_next;
    logic [9:0]  volt_limit_reg, volt_limit_next;

    logic [15:0]        cur_sum_reg, cur_sum_next;
    logic [COUNT_W-1:0] cur_count_reg, cur_count_next;
    logic [15:0]        volt_sum_reg, volt_sum_next;
    logic [COUNT_W-1:0] volt_count_reg, volt_count_next;
    logic [15:0]        offset_reg, offset_next;
    logic [15:0]        cur_held_reg, cur_held_next;
    logic [15:0]        volt_held_reg, volt_held_next;
    logic [31:0]        power_reg, power_next;

    logic        m_valid_reg, m_valid_next;
    dcpm_out_t   m_data_reg, m_data_next;

    logic        mul_start;
    logic [15:0] mul_a, mul_b;
    logic        mul_done;
    logic [31:0] mul_product;

    logic [15:0]        cur_sum_add, volt_sum_add;
    logic [COUNT_W-1:0] cur_count_inc, volt_count_inc;
    logic [15:0]        cur_avg, volt_avg, cur_diff;
    logic [32:0]        rounded;
    logic [15:0]        scaled;

    dcpm_serial_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // Batch arithmetic on the latched item
    assign cur_sum_add    = cur_sum_reg + {6'd0, item_reg.sample};
    assign volt_sum_add   = volt_sum_reg + {6'd0, item_reg.sample};
    assign cur_count_inc  = cur_count_reg + COUNT_W'(1);
    assign volt_count_inc = volt_count_reg + COUNT_W'(1);
    assign cur_avg        = 16'(cur_sum_add << CUR_AVG_SHIFT);
    assign volt_avg       = 16'(volt_sum_add << VOLT_AVG_SHIFT);
    assign cur_diff       = (cur_avg >= offset_reg) ? cur_avg - offset_reg
                                                    : offset_reg - cur_avg;

    // Round half up, drop 14 fraction bits, saturate to 16 bits
    assign rounded = {1'b0, mul_product} + ROUND_HALF;
    assign scaled  = (rounded[32:30] != 3'd0) ? 16'hFFFF : rounded[29:14];

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        status_next     = status_reg;
        cur_gain_next   = cur_gain_reg;
        volt_gain_next  = volt_gain_reg;
        cur_limit_next  = cur_limit_reg;
        volt_limit_next = volt_limit_reg;
        cur_sum_next    = cur_sum_reg;
        cur_count_next  = cur_count_reg;
        volt_sum_next   = volt_sum_reg;
        volt_count_next = volt_count_reg;
        offset_next     = offset_reg;
        cur_held_next   = cur_held_reg;
        volt_held_next  = volt_held_reg;
        power_next      = power_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        mul_start       = 1'b0;
        mul_a           = cur_diff;
        mul_b           = cur_gain_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Register writes
        if (cfg_valid) begin
            case (cfg_index)
                REG_CURRENT_GAIN:  cur_gain_next   = cfg_data;
                REG_VOLTAGE_GAIN:  volt_gain_next  = cfg_data;
                REG_CURRENT_LIMIT: cur_limit_next  = cfg_data[9:0];
                REG_VOLTAGE_LIMIT: volt_limit_next = cfg_data[9:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_IDLE;
                if (item_reg.op inside {OP_MEASURE, OP_CALIB}) begin
                    if (item_reg.sample > cur_limit_reg) begin
                        cur_sum_next   = 16'd0;
                        cur_count_next = '0;
                        status_next    = STATUS_CUR_FAULT;
                        mul_start      = 1'b1;
                        mul_a          = cur_held_reg;
                        mul_b          = volt_held_reg;
                        state_next     = ST_MUL_P;
                    end else if (cur_count_inc == CUR_BATCH) begin
                        cur_sum_next   = 16'd0;
                        cur_count_next = '0;
                        if (item_reg.op == OP_CALIB) begin
                            offset_next = cur_avg;
                            status_next = STATUS_CALIBRATED;
                            mul_start   = 1'b1;
                            mul_a       = cur_held_reg;
                            mul_b       = volt_held_reg;
                            state_next  = ST_MUL_P;
                        end else begin
                            mul_start  = 1'b1;
                            state_next = ST_MUL_I;
                        end
                    end else begin
                        cur_sum_next   = cur_sum_add;
                        cur_count_next = cur_count_inc;
                    end
                end else if (item_reg.op == OP_VOLTAGE) begin
                    if (item_reg.sample > volt_limit_reg) begin
                        volt_sum_next   = 16'd0;
                        volt_count_next = '0;
                        status_next     = STATUS_VOLT_FAULT;
                        mul_start       = 1'b1;
                        mul_a           = cur_held_reg;
                        mul_b           = volt_held_reg;
                        state_next      = ST_MUL_P;
                    end else if (volt_count_inc == VOLT_BATCH) begin
                        volt_sum_next   = 16'd0;
                        volt_count_next = '0;
                        mul_start       = 1'b1;
                        mul_a           = volt_avg;
                        mul_b           = volt_gain_reg;
                        state_next      = ST_MUL_V;
                    end else begin
                        volt_sum_next   = volt_sum_add;
                        volt_count_next = volt_count_inc;
                    end
                end
            end
            ST_MUL_I: begin
                if (mul_done) begin
                    cur_held_next = scaled;
                    state_next    = ST_IDLE;
                end
            end
            ST_MUL_V: begin
                // New voltage held, then the power product
                if (mul_done) begin
                    volt_held_next = scaled;
                    status_next    = STATUS_MEAS_DONE;
                    mul_start      = 1'b1;
                    mul_a          = cur_held_reg;
                    mul_b          = scaled;
                    state_next     = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                if (mul_done) begin
                    power_next = mul_product;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = status_reg;
                    m_data_next.current_ma  = cur_held_reg;
                    m_data_next.voltage_mv  = volt_held_reg;
                    m_data_next.power_uw    = power_reg;
                    m_data_next.zero_offset = offset_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_gain_reg   <= CURRENT_GAIN_RESET;
            volt_gain_reg  <= VOLTAGE_GAIN_RESET;
            cur_limit_reg  <= LIMIT_RESET;
            volt_limit_reg <= LIMIT_RESET;
            cur_sum_reg    <= 16'd0;
            cur_count_reg  <= '0;
            volt_sum_reg   <= 16'd0;
            volt_count_reg <= '0;
            offset_reg     <= OFFSET_RESET;
            cur_held_reg   <= 16'd0;
            volt_held_reg  <= 16'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_gain_reg   <= cur_gain_next;
            volt_gain_reg  <= volt_gain_next;
            cur_limit_reg  <= cur_limit_next;
            volt_limit_reg <= volt_limit_next;
            cur_sum_reg    <= cur_sum_next;
            cur_count_reg  <= cur_count_next;
            volt_sum_reg   <= volt_sum_next;
            volt_count_reg <= volt_count_next;
            offset_reg     <= offset_next;
            cur_held_reg   <= cur_held_next;
            volt_held_reg  <= volt_held_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        status_reg <= status_next;
        power_reg  <= power_next;
        m_data_reg <= m_data_next;
    end

    // Batch counters never reach a full batch between items
    a_cur_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_count_reg < CUR_BATCH) else $error("current batch count overran");

    a_volt_count: assert property (@(posedge aclk) disable iff (!aresetn)
        volt_count_reg < VOLT_BATCH) else $error("voltage batch count overran");

    // Multiplier results only arrive while the sequencer waits for them
    a_mul_done: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_MUL_I || state_reg == ST_MUL_V ||
                      state_reg == ST_MUL_P))
        else $error("multiplier finished outside a multiply state");

    // A result item only appears from the output stage
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output stage");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the DC power monitor averager.
module tb_top import dcpm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package does not name
    localparam logic [1:0] OP_IGNORED     = 2'd3;
    localparam logic [7:0] REG_OUT_OF_MAP = 8'd4;
    localparam logic [7:0] REG_TOP_INDEX  = 8'hFF;

    localparam int BLOCK_LATENCY  = 60;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int PRINT_CAP      = 50;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    dcpm_in_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    dcpm_out_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Predicted register and datapath state
    logic [15:0] cur_gain, volt_gain;
    logic [9:0]  cur_limit, volt_limit;
    logic [15:0] cur_sum, volt_sum;
    logic [COUNT_W-1:0] cur_cnt, volt_cnt;
    logic [15:0] offset_q, cur_held, volt_held;

    dcpm_out_t pending_readings[$];
    dcpm_out_t oldest_reading;

    int mismatch_count = 0;
    int items_sent = 0;
    int readings_seen = 0;
    int fault_readings = 0;
    int reg_writes = 0;
    int burst_left = 0;
    bit pace_en = 1'b1;
    int rx_hold_left = 0;
    int rx_tick = 0;
    int idle_cycles = 0;
    rx_pattern_t rx_mode = RX_OPEN;

    dc_power_monitor_averager u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic void reset_prediction();
        cur_gain   = CURRENT_GAIN_RESET;
        volt_gain  = VOLTAGE_GAIN_RESET;
        cur_limit  = LIMIT_RESET;
        volt_limit = LIMIT_RESET;
        cur_sum    = '0;
        cur_cnt    = '0;
        volt_sum   = '0;
        volt_cnt   = '0;
        offset_q   = OFFSET_RESET;
        cur_held   = '0;
        volt_held  = '0;
    endfunction

    // Q10.6 times Q8.8, round half up, saturate to 16 bits
    function automatic logic [15:0] gain_scale(input logic [15:0] q, input logic [15:0] g);
        logic [32:0] p;
        p = (33'(q) * 33'(g)) + 33'd8192;
        p = p >> 14;
        return (p > 33'd65535) ? 16'hFFFF : p[15:0];
    endfunction

    function automatic void queue_reading(input logic [1:0] status);
        dcpm_out_t r;
        r.status      = status;
        r.current_ma  = cur_held;
        r.voltage_mv  = volt_held;
        r.power_uw    = 32'(cur_held) * 32'(volt_held);
        r.zero_offset = offset_q;
        pending_readings.push_back(r);
    endfunction

    function automatic void predict_reading(input dcpm_in_t it);
        logic [15:0] avg;
        logic [15:0] diff;
        if (it.op == OP_MEASURE || it.op == OP_CALIB) begin
            if (it.sample > cur_limit) begin
                cur_sum = '0;
                cur_cnt = '0;
                queue_reading(STATUS_CUR_FAULT);
            end else begin
                cur_sum = cur_sum + 16'(it.sample);
                cur_cnt = cur_cnt + COUNT_W'(1);
                if (cur_cnt == CUR_BATCH) begin
                    avg = 16'(cur_sum << CUR_AVG_SHIFT);
                    cur_sum = '0;
                    cur_cnt = '0;
                    if (it.op == OP_CALIB) begin
                        offset_q = avg;
                        queue_reading(STATUS_CALIBRATED);
                    end else begin
                        // measurement batch only refreshes the held current
                        diff = (avg >= offset_q) ? avg - offset_q : offset_q - avg;
                        cur_held = gain_scale(diff, cur_gain);
                    end
                end
            end
        end else if (it.op == OP_VOLTAGE) begin
            if (it.sample > volt_limit) begin
                volt_sum = '0;
                volt_cnt = '0;
                queue_reading(STATUS_VOLT_FAULT);
            end else begin
                volt_sum = volt_sum + 16'(it.sample);
                volt_cnt = volt_cnt + COUNT_W'(1);
                if (volt_cnt == VOLT_BATCH) begin
                    avg = 16'(volt_sum << VOLT_AVG_SHIFT);
                    volt_sum = '0;
                    volt_cnt = '0;
                    volt_held = gain_scale(avg, volt_gain);
                    queue_reading(STATUS_MEAS_DONE);
                end
            end
        end
    endfunction

    function automatic void predict_reg_write(input logic [7:0] idx, input logic [15:0] val);
        case (idx)
            REG_CURRENT_GAIN:  cur_gain = val;
            REG_VOLTAGE_GAIN:  volt_gain = val;
            REG_CURRENT_LIMIT: cur_limit = val[9:0];
            REG_VOLTAGE_LIMIT: volt_limit = val[9:0];
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            readings_seen++;
            if (pending_readings.size() == 0) begin
                report_mismatch("result item with nothing expected",
                                32'(m_data.status), 32'd0);
            end else begin
                oldest_reading = pending_readings.pop_front();
                if (oldest_reading.status == STATUS_CUR_FAULT ||
                    oldest_reading.status == STATUS_VOLT_FAULT)
                    fault_readings++;
                if (m_data.status !== oldest_reading.status)
                    report_mismatch("status", 32'(m_data.status),
                                    32'(oldest_reading.status));
                if (m_data.current_ma !== oldest_reading.current_ma)
                    report_mismatch("current_ma", 32'(m_data.current_ma),
                                    32'(oldest_reading.current_ma));
                if (m_data.voltage_mv !== oldest_reading.voltage_mv)
                    report_mismatch("voltage_mv", 32'(m_data.voltage_mv),
                                    32'(oldest_reading.voltage_mv));
                if (m_data.power_uw !== oldest_reading.power_uw)
                    report_mismatch("power_uw", m_data.power_uw, oldest_reading.power_uw);
                if (m_data.zero_offset !== oldest_reading.zero_offset)
                    report_mismatch("zero_offset", 32'(m_data.zero_offset),
                                    32'(oldest_reading.zero_offset));
            end
        end
    end

    // Receiver: long hold-off on request, otherwise a changing stall pattern
    always @(posedge aclk) begin
        rx_tick++;
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_tick % 97 == 0)
                rx_mode = rx_pattern_t'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:  m_ready <= 1'b1;
                RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: m_ready <= ($urandom_range(0, 3) == 0);
                default:  m_ready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding",
                         pending_readings.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic send_sample(input dcpm_in_t it);
        if (pace_en && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        predict_reading(it);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_op(input logic [1:0] op, input logic [9:0] sample);
        dcpm_in_t it;
        it.op = op;
        it.sample = sample;
        send_sample(it);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        predict_reg_write(idx, val);
        reg_writes++;
    endtask

    task automatic apply_setting(input logic [15:0] cg, input logic [15:0] vg,
                                 input logic [15:0] cl, input logic [15:0] vl);
        write_reg(REG_CURRENT_GAIN, cg);
        write_reg(REG_VOLTAGE_GAIN, vg);
        write_reg(REG_CURRENT_LIMIT, cl);
        write_reg(REG_VOLTAGE_LIMIT, vl);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every result is in and the block has finished any silent batch
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (BLOCK_LATENCY) @(posedge aclk);
    endtask

    function automatic logic [9:0] pick_sample(input logic [9:0] lim);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return 10'(480 + $urandom_range(0, 64));
        else if (r < 80)
            return 10'($urandom_range(0, lim));
        else if (r < 90)
            return $urandom_range(0, 1) ? lim : 10'd0;
        else
            return 10'($urandom_range(0, 1023));
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Ignored op, a mixed-tag calibration batch at the sample extremes, faults
    task automatic test_directed_cases();
        send_op(OP_IGNORED, 10'd1023);
        send_op(OP_IGNORED, 10'd0);
        for (int i = 0; i < 16; i++)
            send_op((i % 2) ? OP_CALIB : OP_MEASURE, (i % 2) ? 10'd1023 : 10'd0);
        quiesce();
        // stray indexes must leave the map untouched; limits take the low bits
        write_reg(REG_OUT_OF_MAP, 16'h0000);
        write_reg(REG_TOP_INDEX, 16'hFFFF);
        apply_setting(CURRENT_GAIN_RESET, VOLTAGE_GAIN_RESET, 16'hFC00, 16'hFC00);
        send_op(OP_MEASURE, 10'd1);
        send_op(OP_CALIB, 10'd1023);
        send_op(OP_VOLTAGE, 10'd1);
        send_op(OP_VOLTAGE, 10'd0);
        send_op(OP_MEASURE, 10'd0);
    endtask

    // Receiver holds off while every item faults, so the input has to stall
    task automatic test_output_backpressure();
        quiesce();
        pace_en = 1'b0;
        rx_hold_left = 400;
        for (int i = 0; i < 30; i++)
            send_op((i % 2) ? OP_MEASURE : OP_VOLTAGE, 10'($urandom_range(1, 1023)));
        pace_en = 1'b1;
    endtask

    // Phases of random traffic over a range of gain and limit settings
    task automatic test_register_sweep();
        dcpm_in_t it;
        int unsigned r;
        for (int ph = 0; ph < 10; ph++) begin
            quiesce();
            case (ph)
                0: apply_setting(CURRENT_GAIN_RESET, VOLTAGE_GAIN_RESET, 16'd1023, 16'd1023);
                1: apply_setting(16'd0, 16'd0, 16'd1023, 16'd1023);
                2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: apply_setting(16'hFFFF, 16'd0, 16'd0, 16'd1023);
                4: apply_setting(16'd0, 16'hFFFF, 16'd1023, 16'd0);
                default: apply_setting(16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)),
                                       16'($urandom_range(700, 1023)),
                                       16'($urandom_range(700, 1023)));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    it.op = OP_MEASURE;
                else if (r < 55)
                    it.op = OP_CALIB;
                else if (r < 95)
                    it.op = OP_VOLTAGE;
                else
                    it.op = OP_IGNORED;
                it.sample = pick_sample((it.op == OP_VOLTAGE) ? volt_limit : cur_limit);
                send_sample(it);
            end
        end
    endtask

    task automatic finish_run();
        quiesce();
        $display("run covered %0d samples and %0d register writes over ten settings",
                 items_sent, reg_writes);
        $display("%0d results checked, %0d of them faults, %0d field errors",
                 readings_seen, fault_readings, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    endtask

    initial begin
        reset_prediction();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_output_backpressure();
        test_register_sweep();
        finish_run();
    end

endmodule
